@@ rtl/core/huffman_code_bit_packer_defines.svh @@
// ---------------------------------------------------------------------------
// Prefix-code bit packer: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbp assertion failed");

`endif

@@ rtl/core/hcbp_pkg.sv @@
// ---------------------------------------------------------------------------
// Prefix-code bit packer package
// Beat formats, action codes and fixed widths shared by the packer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  // Fixed field widths.
  localparam int BYTE_BITS  = 8;
  localparam int SYM_BITS   = 8;
  localparam int LEN_BITS   = 6;
  localparam int VALUE_BITS = 32;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  // Command queue depth between front and back (power of two).
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Kind of a queued command.
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [SYM_BITS-1:0]   symbol;
    logic [LEN_BITS-1:0]   code_length;
    logic [VALUE_BITS-1:0] code_value;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/hcbp_front.sv @@
// ---------------------------------------------------------------------------
// Prefix-code bit packer: front end
// Accepts beats, keeps the code table, and turns encode and flush beats into
// aligned code commands for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_code_bit_packer_defines.svh"

module hcbp_front import hcbp_pkg::*; #(
  parameter int SYMBOL_COUNT = 256,
  parameter int LEN_LIMIT    = 32,
  parameter int LEN_W        = 6,
  parameter int ENT_W        = 39
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output logic [ENT_W-1:0]      cmd_data
);

  localparam int AW    = $clog2(SYMBOL_COUNT);
  localparam int MEM_W = LEN_W + LEN_LIMIT;
  localparam logic [SYM_BITS:0]   SYM_END = (SYM_BITS + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_BITS-1:0] LIM_IN  = LEN_BITS'(LEN_LIMIT);
  localparam logic [LEN_W-1:0]    LIM_LW  = LEN_W'(LEN_LIMIT);

  typedef struct packed {
    cmd_kind_t               kind;
    logic [LEN_W-1:0]        len;
    logic [LEN_LIMIT-1:0]    code;
  } qent_t;

  logic [MEM_W-1:0] code_mem_r [SYMBOL_COUNT];
  logic [MEM_W-1:0] rd_data_r;
  logic             s1_valid_r, s1_valid_nxt;
  cmd_kind_t        s1_kind_r;

  logic             accept, in_range, is_load, is_encode, is_flush, issues, push;
  logic [AW-1:0]    sym_idx;
  logic [LEN_W-1:0] len_sat, rd_len, eff_len;
  logic [LEN_LIMIT-1:0] rd_val, eff_val;
  qent_t            ent;

  // Decode the incoming beat.
  assign sym_idx   = in_data.symbol[AW-1:0];
  assign in_range  = {1'b0, in_data.symbol} < SYM_END;
  assign is_load   = in_data.action == ACT_LOAD;
  assign is_encode = in_data.action == ACT_ENCODE;
  assign is_flush  = in_data.action == ACT_FLUSH;
  assign push      = s1_valid_r && cmd_ready;
  assign in_ready  = !s1_valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign issues    = (is_encode && in_range) || is_flush;
  assign len_sat   = (in_data.code_length > LIM_IN) ? LIM_LW
                                                    : in_data.code_length[LEN_W-1:0];

  // Code table: written by load beats, read once per encode beat.
  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      code_mem_r[sym_idx] <= {len_sat, in_data.code_value[LEN_LIMIT-1:0]};
    end
    if (accept && is_encode && in_range) begin
      rd_data_r <= code_mem_r[sym_idx];
    end
  end

  // Issue stage holding one command until the queue takes it.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = issues;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= is_flush ? CMD_FLUSH : CMD_ENCODE;
    end
  end

  // A zero length stands for one zero bit. The code is aligned to the top,
  // which also drops any bits above its length.
  assign rd_len  = rd_data_r[MEM_W-1:LEN_LIMIT];
  assign rd_val  = rd_data_r[LEN_LIMIT-1:0];
  assign eff_len = (rd_len == '0) ? LEN_W'(1) : rd_len;
  assign eff_val = (rd_len == '0) ? '0 : rd_val;

  always_comb begin
    ent.kind  = s1_kind_r;
    ent.len   = eff_len;
    ent.code  = eff_val << (LIM_LW - eff_len);
  end

  assign cmd_valid = s1_valid_r;
  assign cmd_data  = ent;

  // A load beat never leaves a command behind.
  `HCBP_ASSERT_NEXT(a_load_no_cmd, accept && is_load, !s1_valid_r)

endmodule

`default_nettype wire

@@ rtl/core/hcbp_queue.sv @@
// ---------------------------------------------------------------------------
// Prefix-code bit packer: command queue
// Small first-in first-out buffer that decouples front end and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_code_bit_packer_defines.svh"

module hcbp_queue import hcbp_pkg::*; #(
  parameter int DATA_W = 39
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  localparam logic [Q_AW:0] FULL = (Q_AW + 1)'(Q_DEPTH);

  logic [DATA_W-1:0] slots_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r;
  logic              push, pop;

  assign push_ready = count_r != FULL;
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_r + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
    end
  end

  // While the queue is not full, the fill count matches the pointer distance.
  `HCBP_ASSERT_SAME(a_count_ptrs, count_r != FULL, Q_AW'(wr_ptr_r - rd_ptr_r) == count_r[Q_AW-1:0])

endmodule

`default_nettype wire

@@ rtl/core/hcbp_back.sv @@
// ---------------------------------------------------------------------------
// Prefix-code bit packer: back end
// Merges queued codes into the pending bits and sends out one full byte per
// cycle, unless the output stalls, through a registered output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_code_bit_packer_defines.svh"

module hcbp_back import hcbp_pkg::*; #(
  parameter int LEN_LIMIT = 32,
  parameter int LEN_W     = 6,
  parameter int ENT_W     = 39
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire logic [ENT_W-1:0] cmd_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  localparam int ACC_W = LEN_LIMIT + BYTE_BITS;
  localparam int CW    = $clog2(LEN_LIMIT + BYTE_BITS);
  localparam logic [CW-1:0] BYTE_CW = CW'(BYTE_BITS);
  localparam logic [CW-1:0] MAX_CNT = CW'(LEN_LIMIT + BYTE_BITS - 1);

  typedef struct packed {
    cmd_kind_t               kind;
    logic [LEN_W-1:0]        len;
    logic [LEN_LIMIT-1:0]    code;
  } qent_t;

  // Pending bits sit at the top of the accumulator; all bits below are zero.
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  qent_t            ent;
  logic             have_byte, slot_free;
  logic [CW-1:0]    rest;

  assign ent       = cmd_data;
  assign have_byte = cnt_r >= BYTE_CW;
  assign slot_free = !out_valid_r || out_ready;
  assign rest      = cnt_r - BYTE_CW;

  // Emit a full byte first; otherwise take the next command.
  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd_ready     = 1'b0;
    priority if (have_byte) begin
      if (slot_free) begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.out_byte = acc_r[ACC_W-1 -: BYTE_BITS];
        out_data_nxt.last     = rest < BYTE_CW;
        acc_nxt               = acc_r << BYTE_BITS;
        cnt_nxt               = rest;
      end
    end else if (cmd_valid) begin
      unique case (ent.kind)
        CMD_FLUSH: begin
          if (slot_free) begin
            cmd_ready             = 1'b1;
            out_valid_nxt         = 1'b1;
            out_data_nxt.out_byte = acc_r[ACC_W-1 -: BYTE_BITS];
            out_data_nxt.last     = 1'b1;
            acc_nxt               = '0;
            cnt_nxt               = '0;
          end
        end
        CMD_ENCODE: begin
          cmd_ready = 1'b1;
          acc_nxt   = acc_r | ({ent.code, {BYTE_BITS{1'b0}}} >> cnt_r[2:0]);
          cnt_nxt   = cnt_r + CW'(ent.len);
        end
        default: begin
          cmd_ready = 1'b0;
        end
      endcase
    end else begin
      // No whole byte and no queued command: hold everything.
      cmd_ready = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The bit count never grows past one code plus seven pending bits.
  `HCBP_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= MAX_CNT)
  // No command is taken while a whole byte still waits.
  `HCBP_ASSERT_SAME(a_no_pop_full, have_byte, !cmd_ready)
  // A byte ready with a free slot shows up on the output next cycle.
  `HCBP_ASSERT_NEXT(a_emit_byte, have_byte && slot_free, out_valid_r)

endmodule

`default_nettype wire

@@ rtl/core/huffman_code_bit_packer.sv @@
// ---------------------------------------------------------------------------
// Prefix-code bit packer (top level)
// Loads a per-symbol code table, appends symbol codes MSB first into bytes
// and emits each filled byte; flush emits the zero-padded pending byte.
// ---------------------------------------------------------------------------
//   Channel  Ports                       Beat
//   input    in_valid/in_ready/in_data   load, encode or flush item
//   output   out_valid/out_ready/out_data one packed byte with last flag
//
// The front end takes one beat per cycle unless its issue stage waits on a
// full queue; encode reads the table once. The back end merges each code
// into the pending bits and sends out every whole byte before it takes another command.
// Reset (rst_n low, synchronous) clears the pending bits and all handshakes;
// the code table has no reset, so an entry holds no defined code until it is loaded.
// Either side may stall; the four-entry command queue absorbs the difference.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int LEN_LIMIT = (MAX_CODE_BITS < VALUE_BITS) ? MAX_CODE_BITS : VALUE_BITS;
  localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
  localparam int ENT_W     = 1 + LEN_W + LEN_LIMIT;

  logic             f_valid, f_ready;
  logic [ENT_W-1:0] f_data;
  logic             b_valid, b_ready;
  logic [ENT_W-1:0] b_data;

  // Front end: table and command issue.
  hcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .LEN_LIMIT    (LEN_LIMIT),
    .LEN_W        (LEN_W),
    .ENT_W        (ENT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  // Command queue.
  hcbp_queue #(
    .DATA_W (ENT_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // Back end: bit packing and byte output.
  hcbp_back #(
    .LEN_LIMIT (LEN_LIMIT),
    .LEN_W     (LEN_W),
    .ENT_W     (ENT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_data  (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/tb_huffman_code_bit_packer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Prefix-code bit packer testbench
// Loads code table entries and streams encode, flush and unused-action beats
// through the packer. Random stalls hit both channels. Every output byte is
// compared with the result of a local bit-packing predictor that keeps its
// own copy of the code table and of the partly filled byte.
// ---------------------------------------------------------------------------

module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  // The one action code that the packer ignores.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Loaded lengths above this saturate.
  localparam logic [5:0] CODE_LIMIT = 6'd32;
  localparam int RANDOM_BEATS = 112;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Beats waiting to be driven, and the bytes the packer still owes.
  in_item_t  input_beats[$];
  out_item_t expected_bytes[$];

  // Predictor copy of the code table and of the partly filled byte.
  logic [5:0]  code_len_table[256];
  logic [31:0] code_val_table[256];
  logic [7:0]  pend_byte = '0;
  int          pend_bits = 0;

  // Stimulus-side record of which table entries hold a code.
  bit          gen_loaded[256];
  logic [7:0]  loaded_syms[$];

  int          in_gap = 0;
  int          out_gap = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  out_item_t   want;

  huffman_code_bit_packer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall chance in percent, by how much stimulus is left: light stalls,
  // then a clean stretch, then heavy stalls, then none at the tail.
  function automatic int stall_chance();
    int left;
    left = input_beats.size();
    if (left > 110) return 15;
    if (left > 80) return 0;
    if (left > 40) return 40;
    return 0;
  endfunction

  // Work out the bytes one accepted beat produces and update the model state.
  function automatic void pack_item_bytes(input in_item_t beat);
    logic [5:0]  len;
    logic [31:0] bits;
    out_item_t   tail;
    int          produced;
    produced = 0;
    case (beat.action)
      ACT_LOAD: begin
        code_len_table[beat.symbol] =
          (beat.code_length > CODE_LIMIT) ? CODE_LIMIT : beat.code_length;
        code_val_table[beat.symbol] = beat.code_value;
      end
      ACT_ENCODE: begin
        len  = code_len_table[beat.symbol];
        bits = code_val_table[beat.symbol];
        // A zero length stands for the single one-bit zero code.
        if (len == 6'd0) begin
          len  = 6'd1;
          bits = '0;
        end
        for (int i = int'(len) - 1; i >= 0; i--) begin
          if (bits[i]) pend_byte = pend_byte | (8'h80 >> pend_bits);
          pend_bits++;
          if (pend_bits == 8) begin
            if (produced < 4) expected_bytes.push_back('{out_byte: pend_byte, last: 1'b0});
            produced++;
            pend_byte = '0;
            pend_bits = 0;
          end
        end
        if (produced > 0) begin
          tail = expected_bytes.pop_back();
          tail.last = 1'b1;
          expected_bytes.push_back(tail);
        end
      end
      ACT_FLUSH: begin
        expected_bytes.push_back('{out_byte: pend_byte, last: 1'b1});
        pend_byte = '0;
        pend_bits = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_beat(input logic [1:0] action, input logic [7:0] symbol,
                                   input logic [5:0] code_length,
                                   input logic [31:0] code_value);
    in_item_t beat;
    beat.action      = action;
    beat.symbol      = symbol;
    beat.code_length = code_length;
    beat.code_value  = code_value;
    input_beats.push_back(beat);
    if (action == ACT_LOAD && !gen_loaded[symbol]) begin
      gen_loaded[symbol] = 1'b1;
      loaded_syms.push_back(symbol);
    end
  endfunction

  // Mostly short codes, some long ones and a few that saturate.
  function automatic logic [5:0] pick_code_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 6'd0;
    if (r < 70) return 6'($urandom_range(1, 8));
    if (r < 90) return 6'($urandom_range(9, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  // Encode and flush beats carry random filler in the unused fields.
  function automatic void add_encode(input logic [7:0] symbol);
    add_beat(ACT_ENCODE, symbol, 6'($urandom_range(0, 63)), 32'($urandom()));
  endfunction

  function automatic void add_flush();
    add_beat(ACT_FLUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
             32'($urandom()));
  endfunction

  // Input driver: presents the next beat once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (input_beats.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= input_beats.pop_front();
        if ($urandom_range(0, 99) < stall_chance()) in_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap   <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_chance()) out_gap <= $urandom_range(1, 15);
    end
  end

  // Monitor: predict on every accepted input beat, then check the output beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) pack_item_bytes(in_data);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected beat: out_byte 0x%02h last %0b", out_data.out_byte,
                 out_data.last);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte,
                   out_data.out_byte);
            mismatch_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("huffman_code_bit_packer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int counted;
    int r;

    // Directed part: empty flush, ignored action, zero, full and saturated
    // lengths, a four-byte encode and a reload of a used entry.
    add_flush();
    add_beat(ACT_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    add_beat(ACT_LOAD, 8'h00, 6'd0, 32'hFFFF_FFFF);
    add_beat(ACT_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
    add_beat(ACT_LOAD, 8'h01, 6'd63, 32'hA5A5_5A5A);
    add_beat(ACT_LOAD, 8'h02, 6'd33, 32'h8000_0001);
    add_beat(ACT_LOAD, 8'h03, 6'd1, 32'hFFFF_FFFF);
    add_beat(ACT_LOAD, 8'h04, 6'd8, 32'h0000_00C3);
    add_beat(ACT_LOAD, 8'h05, 6'd7, 32'h1234_5655);
    add_encode(8'h00);
    add_encode(8'h00);
    add_encode(8'h03);
    add_encode(8'h00);
    add_encode(8'h03);
    add_encode(8'h00);
    add_encode(8'h03);
    add_encode(8'hFF);
    add_encode(8'h01);
    add_encode(8'h02);
    add_encode(8'h04);
    add_encode(8'h05);
    add_flush();
    add_flush();
    add_beat(ACT_LOAD, 8'h03, 6'd2, 32'h0000_0002);
    add_encode(8'h03);
    add_flush();

    // Random part: mostly encodes of loaded symbols, plus loads, flushes
    // and ignored beats. Ignored beats do not count toward the total.
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 20 || loaded_syms.size() == 0) begin
        add_beat(ACT_LOAD, 8'($urandom_range(0, 255)), pick_code_length(),
                 32'($urandom()));
        counted++;
      end else if (r < 85) begin
        add_encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        counted++;
      end else if (r < 93) begin
        add_flush();
        counted++;
      end else begin
        add_beat(ACT_UNUSED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                 32'($urandom()));
      end
    end
    add_flush();

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then give late extra bytes a chance to show up.
    while (input_beats.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("huffman_code_bit_packer verification clean");
    end else begin
      $display("huffman_code_bit_packer verification failed");
    end
    $finish;
  end

endmodule

@@ huffman_code_bit_packer.f @@
+incdir+rtl/core
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_front.sv
rtl/core/hcbp_queue.sv
rtl/core/hcbp_back.sv
rtl/core/huffman_code_bit_packer.sv
tb/tb_huffman_code_bit_packer.sv
